// ===== hw/rtl/hup_pkg.sv =====
// ----------------------------------------------------------------------------
// hup_pkg
// Shared types and constants for the HTTP URL stream parser.
// ----------------------------------------------------------------------------
package hup_pkg;

  localparam int unsigned MaxPortDigits = 5;

  localparam int unsigned CharW = 8;
  localparam int unsigned RoleW = 3;
  localparam int unsigned PortW = 16;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_SCHEME = 3'd0,
    PH_SLASH1 = 3'd1,
    PH_SLASH2 = 3'd2,
    PH_HOST   = 3'd3,
    PH_PORT   = 3'd4,
    PH_RES    = 3'd5,
    PH_ERR    = 3'd6
  } phase_e;

  // Character role codes.
  localparam logic [RoleW-1:0] ROLE_SCHEME = 3'd0;
  localparam logic [RoleW-1:0] ROLE_SEP    = 3'd1;
  localparam logic [RoleW-1:0] ROLE_HOST   = 3'd2;
  localparam logic [RoleW-1:0] ROLE_PORT   = 3'd3;
  localparam logic [RoleW-1:0] ROLE_RES    = 3'd4;
  localparam logic [RoleW-1:0] ROLE_IGN    = 3'd5;
  localparam logic [RoleW-1:0] ROLE_TERM   = 3'd6;

  localparam logic [CharW-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CharW-1:0] CHAR_COLON = 8'h3A;
  localparam logic [CharW-1:0] CHAR_SLASH = 8'h2F;
  localparam logic [CharW-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CHAR_NINE  = 8'h39;

  // Parser state apart from the digit counter, whose width follows the
  // digit limit.
  typedef struct packed {
    phase_e           phase;
    logic             field_nonempty;
    logic [PortW-1:0] port_accum;
    logic             seen_port;
  } pstate_t;

  // One result word.
  typedef struct packed {
    logic [RoleW-1:0] char_role;
    logic             done_res;
    logic             url_valid;
    logic [PortW-1:0] port_value;
    logic             port_given;
    logic             resource_implied;
  } result_t;

endpackage

// ===== hw/rtl/hup_step.sv =====
// ----------------------------------------------------------------------------
// hup_step
// Next-state and result logic for one URL character.
// ----------------------------------------------------------------------------
module hup_step #(
  parameter int unsigned MAX_PORT_DIGITS = hup_pkg::MaxPortDigits,
  parameter int unsigned DcW             = $clog2(MAX_PORT_DIGITS + 2)
) (
  input  logic [hup_pkg::CharW-1:0] char_i,
  input  hup_pkg::pstate_t          state_i,
  input  logic [DcW-1:0]            dcount_i,
  output hup_pkg::pstate_t          state_o,
  output logic [DcW-1:0]            dcount_o,
  output hup_pkg::result_t          result_o
);

  localparam logic [DcW-1:0] DcMax = DcW'(MAX_PORT_DIGITS);

  logic                      len_ok;
  logic                      is_digit;
  logic [hup_pkg::PortW-1:0] accum_x10;
  logic [hup_pkg::PortW-1:0] digit_val;

  assign len_ok    = (dcount_i != '0) && (dcount_i <= DcMax);
  assign is_digit  = (char_i >= hup_pkg::CHAR_ZERO) && (char_i <= hup_pkg::CHAR_NINE);
  // Times ten as two shifts and an add, wrapping at 16 bits.
  assign accum_x10 = (state_i.port_accum << 3) + (state_i.port_accum << 1);
  assign digit_val = hup_pkg::PortW'(char_i - hup_pkg::CHAR_ZERO);

  always_comb begin
    state_o  = state_i;
    dcount_o = dcount_i;
    result_o = '0;
    result_o.char_role = hup_pkg::ROLE_IGN;

    if (char_i == hup_pkg::CHAR_NUL) begin
      result_o.char_role = hup_pkg::ROLE_TERM;
      result_o.done_res  = 1'b1;
      unique case (state_i.phase)
        hup_pkg::PH_HOST: begin
          result_o.url_valid        = state_i.field_nonempty;
          result_o.resource_implied = state_i.field_nonempty;
        end
        hup_pkg::PH_PORT: begin
          if (len_ok) begin
            result_o.url_valid        = 1'b1;
            result_o.resource_implied = 1'b1;
            result_o.port_value       = state_i.port_accum;
            result_o.port_given       = 1'b1;
          end
        end
        hup_pkg::PH_RES: begin
          result_o.url_valid  = 1'b1;
          result_o.port_value = state_i.port_accum;
          result_o.port_given = state_i.seen_port;
        end
        default: ;
      endcase
      state_o  = '0;
      state_o.phase = hup_pkg::PH_SCHEME;
      dcount_o = '0;
    end else begin
      unique case (state_i.phase)
        hup_pkg::PH_SCHEME: begin
          if (char_i == hup_pkg::CHAR_COLON) begin
            result_o.char_role = hup_pkg::ROLE_SEP;
            state_o.phase      = hup_pkg::PH_SLASH1;
          end else begin
            result_o.char_role = hup_pkg::ROLE_SCHEME;
          end
        end
        hup_pkg::PH_SLASH1, hup_pkg::PH_SLASH2: begin
          if (char_i == hup_pkg::CHAR_SLASH) begin
            result_o.char_role = hup_pkg::ROLE_SEP;
            state_o.phase = (state_i.phase == hup_pkg::PH_SLASH1) ?
                            hup_pkg::PH_SLASH2 : hup_pkg::PH_HOST;
          end else begin
            state_o.phase = hup_pkg::PH_ERR;
          end
        end
        hup_pkg::PH_HOST: begin
          if (char_i == hup_pkg::CHAR_COLON || char_i == hup_pkg::CHAR_SLASH) begin
            if (!state_i.field_nonempty) begin
              state_o.phase = hup_pkg::PH_ERR;
            end else if (char_i == hup_pkg::CHAR_COLON) begin
              result_o.char_role = hup_pkg::ROLE_SEP;
              state_o.phase      = hup_pkg::PH_PORT;
              state_o.seen_port  = 1'b1;
            end else begin
              result_o.char_role = hup_pkg::ROLE_RES;
              state_o.phase      = hup_pkg::PH_RES;
            end
          end else begin
            result_o.char_role     = hup_pkg::ROLE_HOST;
            state_o.field_nonempty = 1'b1;
          end
        end
        hup_pkg::PH_PORT: begin
          if (char_i == hup_pkg::CHAR_SLASH) begin
            if (len_ok) begin
              result_o.char_role = hup_pkg::ROLE_RES;
              state_o.phase      = hup_pkg::PH_RES;
            end else begin
              state_o.phase = hup_pkg::PH_ERR;
            end
          end else if (is_digit) begin
            result_o.char_role = hup_pkg::ROLE_PORT;
            state_o.port_accum = accum_x10 + digit_val;
            // The counter stops one past the limit so an overlong port stays visible.
            if (dcount_i <= DcMax) begin
              dcount_o = dcount_i + 1'b1;
            end
          end else begin
            state_o.phase = hup_pkg::PH_ERR;
          end
        end
        hup_pkg::PH_RES: begin
          result_o.char_role = hup_pkg::ROLE_RES;
        end
        default: begin
          state_o.phase = hup_pkg::PH_ERR;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/http_url_stream_parser.sv =====
// ----------------------------------------------------------------------------
// http_url_stream_parser
// Streaming URL checker: tags each character and reports the parse at NUL.
// ----------------------------------------------------------------------------
// A word's result is registered: an accepted word waits in the input register
// and moves on to the result register when the processing step fires.
// Throughput: one word per cycle while the receiver does not stall; the parser
// state updates from the input register, so the state loop sets that rate.
// Reset: rst_ni clears the parser to the scheme phase and empties both
// the input register and the result register asynchronously.
// ----------------------------------------------------------------------------
module http_url_stream_parser #(
  parameter int unsigned MAX_PORT_DIGITS = hup_pkg::MaxPortDigits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [hup_pkg::CharW-1:0] char_in_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [hup_pkg::RoleW-1:0] char_role_o,
  output logic                      done_res_o,
  output logic                      url_valid_o,
  output logic [hup_pkg::PortW-1:0] port_value_o,
  output logic                      port_given_o,
  output logic                      resource_implied_o
);

  // Wide enough to hold one count past the digit limit.
  localparam int unsigned DcW = $clog2(MAX_PORT_DIGITS + 2);

  // Input register. It is refilled whenever its word moves on, so a new
  // word is taken even while a finished result waits on the output.
  logic                      in_valid_q;
  logic [hup_pkg::CharW-1:0] char_q;

  // Parser state, updated once for each word that leaves the input register.
  hup_pkg::pstate_t state_q, state_d;
  logic [DcW-1:0]   dcount_q, dcount_d;

  // Result register.
  logic             out_valid_q;
  hup_pkg::result_t result_q, result_d;

  logic advance;
  logic in_load;

  // The processing step fires when the result register is free or drains now.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_load    = in_valid_i && !in_stall_o;

  hup_step #(
    .MAX_PORT_DIGITS(MAX_PORT_DIGITS),
    .DcW            (DcW)
  ) u_step (
    .char_i  (char_q),
    .state_i (state_q),
    .dcount_i(dcount_q),
    .state_o (state_d),
    .dcount_o(dcount_d),
    .result_o(result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
      dcount_q    <= '0;
    end else begin
      if (in_load) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
        dcount_q    <= dcount_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      char_q <= char_in_i;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign char_role_o        = result_q.char_role;
  assign done_res_o         = result_q.done_res;
  assign url_valid_o        = result_q.url_valid;
  assign port_value_o       = result_q.port_value;
  assign port_given_o       = result_q.port_given;
  assign resource_implied_o = result_q.resource_implied;

  // The summary fields are zero except on an accepted terminator.
  a_summary_only_valid_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !(result_q.done_res && result_q.url_valid) |->
      result_q.port_value == '0 && !result_q.port_given && !result_q.resource_implied)
    else $error("summary fields set without a valid terminator");

  // A terminator is tagged as such, and only a terminator is.
  a_term_role : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (result_q.done_res == (result_q.char_role == hup_pkg::ROLE_TERM)))
    else $error("terminator role and done flag disagree");

  // A processed NUL puts the parser back into its reset state.
  a_nul_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && char_q == hup_pkg::CHAR_NUL |=>
      state_q.phase == hup_pkg::PH_SCHEME && dcount_q == '0 && !state_q.seen_port)
    else $error("parser not cleared after terminator");

  // The digit counter never runs past one beyond the limit.
  a_dcount_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dcount_q <= DcW'(MAX_PORT_DIGITS + 1))
    else $error("port digit counter overran");

  // Parser state only moves when a word is processed.
  a_state_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q) && $stable(dcount_q))
    else $error("parser state changed without a word");

endmodule

// ===== bench/tb_http_url_stream_parser.sv =====
// ----------------------------------------------------------------------------
// tb_http_url_stream_parser
// Self-checking bench for the streaming URL parser.
// ----------------------------------------------------------------------------
// URL strings are fed to the parser one character per word. A short directed
// run covers the corner cases. Most of the random strings have a well-formed
// shape with random content, and the rest are broken strings or noise. Each
// accepted character is run through a cycle-free model of the parser state
// machine, and the model's result word is queued. Every result word the
// parser hands out is compared field by field with the oldest queued word.
// Both handshake sides idle and stall at random. The run also includes one
// long receiver hold-off that backs the parser up, and pauses in which the
// sender waits until the parser has drained.
// ----------------------------------------------------------------------------
module tb_http_url_stream_parser;
  import hup_pkg::*;

  // The limit assumes a slow but correct run of about 1100 words, each with
  // the longest sender idle gap and the longest receiver stall, and is then
  // taken several times over.
  localparam int unsigned CycleLimit    = 400000;
  // The parser shows a word's result once the word has passed its input register
  // and its result register; the tail adds margin for a stray word.
  localparam int unsigned TailCycles    = 8;
  localparam int unsigned HoldOffCycles = 150;
  localparam int unsigned RandomChars   = 1000;
  localparam int unsigned ReportLimit   = 10;

  // --------------------------------------------------------------------------
  // Parser model and queue of expected result words.
  // --------------------------------------------------------------------------
  class url_parse_tracker;
    phase_e           phase;
    bit               host_seen;
    int unsigned      digit_count;
    logic [PortW-1:0] port_accum;
    bit               seen_port;
    result_t          due_words[$];
    int unsigned      mismatches;

    function new();
      clear();
      mismatches = 0;
    endfunction

    function void clear();
      phase       = PH_SCHEME;
      host_seen   = 1'b0;
      digit_count = 0;
      port_accum  = '0;
      seen_port   = 1'b0;
    endfunction

    function bit port_len_ok();
      return digit_count != 0 && digit_count <= MaxPortDigits;
    endfunction

    function int unsigned outstanding();
      return due_words.size();
    endfunction

    // Advances the model by one accepted character and queues its result.
    function void take_char(logic [CharW-1:0] c);
      result_t w;
      w = '0;
      w.char_role = ROLE_IGN;
      if (c == CHAR_NUL) begin
        w.char_role = ROLE_TERM;
        w.done_res  = 1'b1;
        case (phase)
          PH_HOST: begin
            if (host_seen) begin
              w.url_valid        = 1'b1;
              w.resource_implied = 1'b1;
            end
          end
          PH_PORT: begin
            if (port_len_ok()) begin
              w.url_valid        = 1'b1;
              w.resource_implied = 1'b1;
              w.port_value       = port_accum;
              w.port_given       = 1'b1;
            end
          end
          PH_RES: begin
            w.url_valid  = 1'b1;
            w.port_value = port_accum;
            w.port_given = seen_port;
          end
          default: ;
        endcase
        clear();
      end else begin
        case (phase)
          PH_SCHEME: begin
            if (c == CHAR_COLON) begin
              w.char_role = ROLE_SEP;
              phase       = PH_SLASH1;
            end else begin
              w.char_role = ROLE_SCHEME;
            end
          end
          PH_SLASH1, PH_SLASH2: begin
            if (c == CHAR_SLASH) begin
              w.char_role = ROLE_SEP;
              phase       = (phase == PH_SLASH1) ? PH_SLASH2 : PH_HOST;
            end else begin
              phase = PH_ERR;
            end
          end
          PH_HOST: begin
            if (c == CHAR_COLON || c == CHAR_SLASH) begin
              if (!host_seen) begin
                phase = PH_ERR;
              end else if (c == CHAR_COLON) begin
                w.char_role = ROLE_SEP;
                phase       = PH_PORT;
                seen_port   = 1'b1;
              end else begin
                w.char_role = ROLE_RES;
                phase       = PH_RES;
              end
            end else begin
              w.char_role = ROLE_HOST;
              host_seen   = 1'b1;
            end
          end
          PH_PORT: begin
            if (c == CHAR_SLASH) begin
              if (port_len_ok()) begin
                w.char_role = ROLE_RES;
                phase       = PH_RES;
              end else begin
                phase = PH_ERR;
              end
            end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
              w.char_role = ROLE_PORT;
              port_accum  = 16'(port_accum * 10 + (c - CHAR_ZERO));
              if (digit_count <= MaxPortDigits) begin
                digit_count++;
              end
            end else begin
              phase = PH_ERR;
            end
          end
          PH_RES: begin
            w.char_role = ROLE_RES;
          end
          default: begin
            phase = PH_ERR;
          end
        endcase
      end
      due_words.push_back(w);
    endfunction

    // Compares one result word from the parser with the oldest queued word.
    function void check_word(result_t got);
      result_t want;
      if (due_words.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("unexpected word: role %0d done %0b valid %0b port %0d given %0b impl %0b",
                   got.char_role, got.done_res, got.url_valid, got.port_value,
                   got.port_given, got.resource_implied);
        end
        return;
      end
      want = due_words.pop_front();
      if (got.char_role !== want.char_role || got.done_res !== want.done_res ||
          got.url_valid !== want.url_valid || got.port_value !== want.port_value ||
          got.port_given !== want.port_given ||
          got.resource_implied !== want.resource_implied) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("mismatch: exp role %0d done %0b valid %0b port %0d given %0b impl %0b",
                   want.char_role, want.done_res, want.url_valid, want.port_value,
                   want.port_given, want.resource_implied);
          $display("          got role %0d done %0b valid %0b port %0d given %0b impl %0b",
                   got.char_role, got.done_res, got.url_valid, got.port_value,
                   got.port_given, got.resource_implied);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test. Every input has a known value from time zero.
  // --------------------------------------------------------------------------
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic [CharW-1:0] char_in_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [RoleW-1:0] char_role_o;
  logic             done_res_o;
  logic             url_valid_o;
  logic [PortW-1:0] port_value_o;
  logic             port_given_o;
  logic             resource_implied_o;

  http_url_stream_parser dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .char_in_i          (char_in_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .char_role_o        (char_role_o),
    .done_res_o         (done_res_o),
    .url_valid_o        (url_valid_o),
    .port_value_o       (port_value_o),
    .port_given_o       (port_given_o),
    .resource_implied_o (resource_implied_o)
  );

  url_parse_tracker tracker = new();

  // While calm is set, neither side idles. A hold-off request makes the
  // receiver stall for a long, fixed stretch.
  bit               calm         = 1'b0;
  bit               hold_off_req = 1'b0;
  logic [CharW-1:0] char_q[$];
  int unsigned      sent_chars   = 0;
  int unsigned      cycle_cnt    = 0;
  result_t          out_word;

  assign out_word = {char_role_o, done_res_o, url_valid_o, port_value_o,
                     port_given_o, resource_implied_o};

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Both handshakes are sampled at the rising edge. All inputs change by
  // nonblocking assignment at that edge, so the values seen here are the
  // ones that were present just before it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        tracker.take_char(char_in_i);
      end
      if (out_valid_o && !out_stall_i) begin
        tracker.check_word(out_word);
      end
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb_http_url_stream_parser: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. Unless calm or a hold-off is set, it takes words for a while, then
  // stalls. Most stalls are short and a few are long. Every branch waits on the
  // clock after each assignment to the stall input, so the stall input is assigned
  // at most once per time step.
  // --------------------------------------------------------------------------
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
      end else if (calm) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(20, 60)) @(posedge clk_i);
        end else begin
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end
        out_stall_i <= 1'b1;
        if ($urandom_range(0, 99) < 80) begin
          repeat ($urandom_range(1, 3)) @(posedge clk_i);
        end else begin
          repeat ($urandom_range(8, 30)) @(posedge clk_i);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender.
  // --------------------------------------------------------------------------
  function automatic int unsigned idle_len();
    int unsigned r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 25);
  endfunction

  // Offers one word and returns at the edge where it is taken. Valid stays
  // high afterward, so a back-to-back word needs only a new character.
  task automatic send_char(logic [CharW-1:0] c);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_in_i  <= c;
    do @(posedge clk_i); while (in_stall_o);
    sent_chars++;
  endtask

  task automatic send_queued();
    while (char_q.size() != 0) begin
      send_char(char_q.pop_front());
    end
  endtask

  // Stops offering words and waits until every expected word is back. It
  // then lets the pipeline run on for a tail so that any stray word shows.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.outstanding() != 0);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  function automatic void queue_text(string s);
    foreach (s[i]) begin
      char_q.push_back(s[i]);
    end
  endfunction

  // Returns a random nonzero byte, leaving out the colon and/or the slash
  // when they would change the field that is being built.
  function automatic logic [CharW-1:0] pick_byte(bit no_colon, bit no_slash);
    logic [CharW-1:0] b;
    do begin
      b = CharW'($urandom_range(1, 255));
    end while ((no_colon && b == CHAR_COLON) || (no_slash && b == CHAR_SLASH));
    return b;
  endfunction

  // Builds one random string and queues it, including its terminating NUL.
  // Most strings follow scheme://host[:port][/resource] with random content.
  // Some have a broken separator, an empty host or a bad port, and a few
  // are plain noise.
  task automatic queue_random_url();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      // Noise that is rich in separator and digit characters.
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 3))
          0:       char_q.push_back(CHAR_COLON);
          1:       char_q.push_back(CHAR_SLASH);
          2:       char_q.push_back(CHAR_ZERO + CharW'($urandom_range(0, 9)));
          default: char_q.push_back(pick_byte(1'b0, 1'b0));
        endcase
      end
    end else begin
      repeat ($urandom_range(0, 4)) char_q.push_back(pick_byte(1'b1, 1'b0));
      // A few strings end before the scheme colon.
      if (kind >= 12) begin
        char_q.push_back(CHAR_COLON);
        repeat (2) begin
          if ($urandom_range(0, 39) == 0) begin
            char_q.push_back(pick_byte(1'b0, 1'b1));
          end else begin
            char_q.push_back(CHAR_SLASH);
          end
        end
        n = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 5);
        repeat (n) char_q.push_back(pick_byte(1'b1, 1'b1));
        if ($urandom_range(0, 99) < 45) begin
          char_q.push_back(CHAR_COLON);
          // Mostly legal lengths, sometimes none or too many. Five digits
          // can go past 65535, which checks the 16-bit wrap.
          if ($urandom_range(0, 99) < 85) begin
            n = $urandom_range(1, MaxPortDigits);
          end else begin
            n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(MaxPortDigits + 1, 7);
          end
          repeat (n) char_q.push_back(CHAR_ZERO + CharW'($urandom_range(0, 9)));
          if ($urandom_range(0, 19) == 0) begin
            char_q.push_back(pick_byte(1'b0, 1'b1));
          end
        end
        if ($urandom_range(0, 1) == 0) begin
          char_q.push_back(CHAR_SLASH);
          repeat ($urandom_range(0, 6)) char_q.push_back(pick_byte(1'b0, 1'b0));
        end
      end
    end
    char_q.push_back(CHAR_NUL);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed strings. They cover an empty string with no colon, a missing
    // slash, an empty host at the end and before a port, the largest port
    // with 16-bit wrap, a resource with an all-ones byte, a port that is too
    // long at the end of the string, and a stray colon after a port.
    char_q.push_back(CHAR_NUL);
    queue_text(":x");
    char_q.push_back(CHAR_NUL);
    queue_text("://");
    char_q.push_back(CHAR_NUL);
    queue_text("://:");
    char_q.push_back(CHAR_NUL);
    queue_text("a://h:99999/");
    char_q.push_back(8'hFF);
    char_q.push_back(CHAR_NUL);
    queue_text("://h:123456");
    char_q.push_back(CHAR_NUL);
    queue_text("://h:1:");
    char_q.push_back(CHAR_NUL);
    send_queued();
    drain();

    // A stretch where neither side idles.
    calm = 1'b1;
    repeat (4) queue_random_url();
    send_queued();
    calm = 1'b0;

    // The receiver holds off for a long time while the sender keeps
    // offering words. The sender only starts once the hold-off is under
    // way, so the parser fills up and must stall its input. After that,
    // the sender waits until the parser is empty.
    calm         = 1'b1;
    hold_off_req = 1'b1;
    in_valid_i  <= 1'b0;
    do @(posedge clk_i); while (hold_off_req);
    repeat (5) queue_random_url();
    send_queued();
    calm = 1'b0;
    drain();

    sent_chars = 0;
    while (sent_chars < RandomChars) begin
      queue_random_url();
      send_queued();
      if ($urandom_range(0, 19) == 0) begin
        drain();
      end
    end
    drain();

    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("tb_http_url_stream_parser: clean");
    end else begin
      $display("tb_http_url_stream_parser: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/hup_pkg.sv
hw/rtl/hup_step.sv
hw/rtl/http_url_stream_parser.sv
bench/tb_http_url_stream_parser.sv
